// File: rtl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Shared widths, codes and types of the UART ring buffer with flow control.
// ----------------------------------------------------------------------------
package urb_pkg;

	localparam int CAP_W      = 10;
	localparam int DATA_W     = 8;
	localparam int CNT_W      = 32;
	localparam int OP_W       = 3;
	localparam int MODE_W     = 2;
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 4;

	localparam int STORE_DEPTH_DEF = 1024;
	localparam int QUEUE_DEPTH     = 2;

	// base plus position stays below this span
	localparam int SUM_SPAN = 1 << (CAP_W + 1);

	localparam logic [DATA_W-1:0] XON_CODE  = 8'd17;
	localparam logic [DATA_W-1:0] XOFF_CODE = 8'd19;

	localparam logic [OP_W-1:0] OP_RX      = 3'd0;
	localparam logic [OP_W-1:0] OP_RX_PERR = 3'd1;
	localparam logic [OP_W-1:0] OP_HOST_WR = 3'd2;
	localparam logic [OP_W-1:0] OP_HOST_RD = 3'd3;
	localparam logic [OP_W-1:0] OP_TX_FREE = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd5;

	localparam logic [MODE_W-1:0] FLOW_SW = 2'd1;
	localparam logic [MODE_W-1:0] FLOW_HW = 2'd2;

	localparam logic [1:0] REG_FLOW_MODE = 2'd0;
	localparam logic [1:0] REG_RX_CAP    = 2'd1;
	localparam logic [1:0] REG_TX_CAP    = 2'd2;
	localparam logic [1:0] REG_RX_LIMIT  = 2'd3;

	localparam logic [MODE_W-1:0] RST_FLOW_MODE = 2'd0;
	localparam logic [CAP_W-1:0]  RST_RX_CAP    = 10'd512;
	localparam logic [CAP_W-1:0]  RST_TX_CAP    = 10'd512;
	localparam logic [CAP_W-1:0]  RST_RX_LIMIT  = 10'd32;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_RX_STORE,
		CMD_XON,
		CMD_XOFF,
		CMD_HOST_WR,
		CMD_HOST_RD,
		CMD_TX_POP,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              parity;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] flow_mode;
		logic [CAP_W-1:0]  rx_capacity;
		logic [CAP_W-1:0]  tx_capacity;
		logic [CAP_W-1:0]  rx_free_limit;
	} cfg_t;

	typedef enum logic {
		BK_IDLE,
		BK_FINISH
	} back_state_t;

endpackage

// File: rtl/urb_in_if.sv
// ----------------------------------------------------------------------------
// urb_in_if
// Input item channel: line and host events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface urb_in_if;

	logic                        valid;
	logic                        ready;
	logic [urb_pkg::OP_W-1:0]    opcode;
	logic [urb_pkg::DATA_W-1:0]  data_in;
	logic                        cts_level;

	modport source (output valid, output opcode, output data_in, output cts_level,
		input ready);
	modport sink (input valid, input opcode, input data_in, input cts_level,
		output ready);

endinterface

// File: rtl/urb_out_if.sv
// ----------------------------------------------------------------------------
// urb_out_if
// Result item channel: popped byte and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface urb_out_if;

	logic                        valid;
	logic                        ready;
	logic [urb_pkg::DATA_W-1:0]  data_out;
	logic                        data_valid;
	logic                        accepted;
	logic                        rts_high;
	logic                        tx_paused;
	logic                        rx_waiting;
	logic [urb_pkg::CAP_W-1:0]   rx_used;
	logic [urb_pkg::CAP_W-1:0]   tx_used;
	logic [urb_pkg::CNT_W-1:0]   overrun_count;
	logic [urb_pkg::CNT_W-1:0]   parity_count;
	logic                        errors_changed;

	modport source (output valid, output data_out, output data_valid, output accepted,
		output rts_high, output tx_paused, output rx_waiting, output rx_used,
		output tx_used, output overrun_count, output parity_count,
		output errors_changed, input ready);
	modport sink (input valid, input data_out, input data_valid, input accepted,
		input rts_high, input tx_paused, input rx_waiting, input rx_used,
		input tx_used, input overrun_count, input parity_count,
		input errors_changed, output ready);

endinterface

// File: rtl/uart_ring_buffer_flow_control.sv
// ----------------------------------------------------------------------------
// uart_ring_buffer_flow_control
// UART receive and transmit rings in one byte store, with XON/XOFF and
// RTS/CTS flow control and error counter snapshots.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event per item (line byte, host write/read, transmit
//   slot free, tick) with its data byte and the CTS level. out_ch returns one
//   status item per input item, in order: popped byte, stored flag, flow
//   control pins and flags, ring fill levels and the error counters.
//   Registers are to be written over APB only while the block is idle, which
//   the block itself does not enforce; a capacity write empties both rings.
//   An item sits in a two-entry command queue, then the back end takes it
//   through a store access step and a result step, which loads the result
//   register. The back end takes the next item only after the result step
//   of the last one.
//   When out_ch stalls, the result holds; up to two further items are still
//   taken into the queue, then in_ch.ready drops.
//   Reset empties both rings, clears flags and counters and loads register
//   defaults at once; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_ring_buffer_flow_control #(
	parameter int STORE_DEPTH = urb_pkg::STORE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	urb_in_if.sink                            in_ch,
	urb_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [urb_pkg::PADDR_W-1:0]       paddr,
	input  logic [urb_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [urb_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	urb_pkg::cfg_t cfg;
	logic          rings_clear;
	logic          q_push, q_full, q_pop, q_valid;
	urb_pkg::cmd_t push_cmd, head_cmd;

	urb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cfg         (cfg),
		.rings_clear (rings_clear)
	);

	urb_front u_front (
		.in_ch     (in_ch),
		.flow_mode (cfg.flow_mode),
		.q_full    (q_full),
		.push      (q_push),
		.cmd       (push_cmd)
	);

	urb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_cmd),
		.valid    (q_valid)
	);

	urb_back #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.rings_clear (rings_clear),
		.cmd_valid   (q_valid),
		.cmd         (head_cmd),
		.cmd_pop     (q_pop),
		.out_ch      (out_ch)
	);

endmodule

// File: rtl/urb_ram.sv
// ----------------------------------------------------------------------------
// urb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module urb_ram #(
	parameter int WIDTH = urb_pkg::DATA_W,
	parameter int DEPTH = urb_pkg::STORE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/urb_regs.sv
// ----------------------------------------------------------------------------
// urb_regs
// APB configuration registers: flow mode, ring capacities, throttle limit.
// ----------------------------------------------------------------------------
module urb_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [urb_pkg::PADDR_W-1:0]       paddr,
	input  logic [urb_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [urb_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output urb_pkg::cfg_t                     cfg,
	output logic                              rings_clear
);

	urb_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[urb_pkg::PADDR_W-1:2];
	assign cfg     = cfg_q;

	// a capacity change empties both rings
	assign rings_clear = wr_en &&
		(reg_idx == urb_pkg::REG_RX_CAP || reg_idx == urb_pkg::REG_TX_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flow_mode     <= urb_pkg::RST_FLOW_MODE;
			cfg_q.rx_capacity   <= urb_pkg::RST_RX_CAP;
			cfg_q.tx_capacity   <= urb_pkg::RST_TX_CAP;
			cfg_q.rx_free_limit <= urb_pkg::RST_RX_LIMIT;
		end else if (wr_en) begin
			unique case (reg_idx)
				urb_pkg::REG_FLOW_MODE: cfg_q.flow_mode     <= pwdata[urb_pkg::MODE_W-1:0];
				urb_pkg::REG_RX_CAP:    cfg_q.rx_capacity   <= pwdata[urb_pkg::CAP_W-1:0];
				urb_pkg::REG_TX_CAP:    cfg_q.tx_capacity   <= pwdata[urb_pkg::CAP_W-1:0];
				urb_pkg::REG_RX_LIMIT:  cfg_q.rx_free_limit <= pwdata[urb_pkg::CAP_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			urb_pkg::REG_FLOW_MODE: prdata = urb_pkg::APB_DATA_W'(cfg_q.flow_mode);
			urb_pkg::REG_RX_CAP:    prdata = urb_pkg::APB_DATA_W'(cfg_q.rx_capacity);
			urb_pkg::REG_TX_CAP:    prdata = urb_pkg::APB_DATA_W'(cfg_q.tx_capacity);
			urb_pkg::REG_RX_LIMIT:  prdata = urb_pkg::APB_DATA_W'(cfg_q.rx_free_limit);
		endcase
	end

endmodule

// File: rtl/urb_front.sv
// ----------------------------------------------------------------------------
// urb_front
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module urb_front (
	urb_in_if.sink                       in_ch,
	input  logic [urb_pkg::MODE_W-1:0]   flow_mode,
	input  logic                         q_full,
	output logic                         push,
	output urb_pkg::cmd_t                cmd
);

	logic sw_mode;

	assign sw_mode     = (flow_mode == urb_pkg::FLOW_SW);
	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		cmd.kind   = urb_pkg::CMD_NOP;
		cmd.parity = (in_ch.opcode == urb_pkg::OP_RX_PERR);
		cmd.data   = in_ch.data_in;
		unique case (in_ch.opcode) inside
			urb_pkg::OP_RX, urb_pkg::OP_RX_PERR: begin
				// consume flow control bytes in software mode
				if (sw_mode && in_ch.data_in == urb_pkg::XON_CODE) begin
					cmd.kind = urb_pkg::CMD_XON;
				end else if (sw_mode && in_ch.data_in == urb_pkg::XOFF_CODE) begin
					cmd.kind = urb_pkg::CMD_XOFF;
				end else begin
					cmd.kind = urb_pkg::CMD_RX_STORE;
				end
			end
			urb_pkg::OP_HOST_WR: cmd.kind = urb_pkg::CMD_HOST_WR;
			urb_pkg::OP_HOST_RD: cmd.kind = urb_pkg::CMD_HOST_RD;
			urb_pkg::OP_TX_FREE: begin
				// partner not ready: report status only
				if (flow_mode == urb_pkg::FLOW_HW && in_ch.cts_level) begin
					cmd.kind = urb_pkg::CMD_NOP;
				end else begin
					cmd.kind = urb_pkg::CMD_TX_POP;
				end
			end
			urb_pkg::OP_TICK: cmd.kind = urb_pkg::CMD_TICK;
			default: cmd.kind = urb_pkg::CMD_NOP;
		endcase
	end

endmodule

// File: rtl/urb_queue.sv
// ----------------------------------------------------------------------------
// urb_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module urb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  urb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output urb_pkg::cmd_t head,
	output logic          valid
);

	localparam int PW = $clog2(urb_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(urb_pkg::QUEUE_DEPTH + 1);

	urb_pkg::cmd_t  entry_q [urb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(urb_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(urb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(urb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/urb_back.sv
// ----------------------------------------------------------------------------
// urb_back
// Executes commands on the shared byte store, ring positions, flow control
// flags and error counters; holds the result register.
// ----------------------------------------------------------------------------
module urb_back #(
	parameter int STORE_DEPTH = urb_pkg::STORE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  urb_pkg::cfg_t cfg,
	input  logic          rings_clear,
	input  logic          cmd_valid,
	input  urb_pkg::cmd_t cmd,
	output logic          cmd_pop,
	urb_out_if.source     out_ch
);

	localparam int AW        = $clog2(STORE_DEPTH);
	localparam int MW        = urb_pkg::CAP_W + AW + 2;
	localparam int MOD_STEPS = $clog2(urb_pkg::SUM_SPAN / STORE_DEPTH + 1);
	localparam int CW        = urb_pkg::CAP_W;
	localparam int NW        = urb_pkg::CNT_W;

	typedef struct packed {
		logic [urb_pkg::DATA_W-1:0] data_out;
		logic                       data_valid;
		logic                       accepted;
		logic                       rts_high;
		logic                       tx_paused;
		logic                       rx_waiting;
		logic [CW-1:0]              rx_used;
		logic [CW-1:0]              tx_used;
		logic [NW-1:0]              overrun_count;
		logic [NW-1:0]              parity_count;
		logic                       errors_changed;
	} result_t;

	// base plus position, wrapped to the store by restoring subtraction
	function automatic logic [AW-1:0] store_addr(logic [CW-1:0] base, logic [CW-1:0] pos);
		logic [MW-1:0] r;
		r = MW'(base) + MW'(pos);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (r >= (MW'(STORE_DEPTH) << k)) begin
				r = r - (MW'(STORE_DEPTH) << k);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [CW-1:0] ring_next(logic [CW-1:0] p, logic [CW-1:0] cap);
		logic [CW:0] n;
		n = {1'b0, p} + 1'b1;
		return (n >= {1'b0, cap}) ? '0 : n[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] ring_used(logic [CW-1:0] rd, logic [CW-1:0] wr,
		logic [CW-1:0] cap);
		return (wr < rd) ? CW'(cap + wr - rd) : CW'(wr - rd);
	endfunction

	urb_pkg::back_state_t state_q, state_d;

	logic [CW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [CW-1:0] rx_head_d, rx_tail_d, tx_head_d, tx_tail_d;
	logic          xoff_pend_q, rx_wait_q, tx_wait_q, rts_q;
	logic          xoff_pend_d, rx_wait_d, tx_wait_d, rts_d;
	logic [NW-1:0] overrun_q, parity_q, overrun_snap_q, parity_snap_q;
	logic [NW-1:0] overrun_d, parity_d, overrun_snap_d, parity_snap_d;

	logic valid_s1, acc_s1, changed_s1;
	logic valid_d, acc_d, changed_d;

	logic    out_valid_q;
	result_t res_q;

	logic go, load_res;

	logic [CW-1:0] rx_used_now, rx_tail_nx, rx_head_nx, tx_tail_nx, tx_head_nx;
	logic [CW:0]   free_w;
	logic          room_above, rx_full, rx_empty, tx_full, tx_empty;
	logic          sw_mode, hw_mode;

	logic                       ram_en, ram_we;
	logic [AW-1:0]              ram_addr;
	logic [urb_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

	assign sw_mode = (cfg.flow_mode == urb_pkg::FLOW_SW);
	assign hw_mode = (cfg.flow_mode == urb_pkg::FLOW_HW);

	assign rx_used_now = ring_used(rx_head_q, rx_tail_q, cfg.rx_capacity);
	assign free_w      = {1'b0, cfg.rx_capacity} - {1'b0, rx_used_now};
	// a negative free count means plenty of room
	assign room_above  = free_w[CW] || (free_w[CW-1:0] > cfg.rx_free_limit);

	assign rx_tail_nx = ring_next(rx_tail_q, cfg.rx_capacity);
	assign rx_head_nx = ring_next(rx_head_q, cfg.rx_capacity);
	assign tx_tail_nx = ring_next(tx_tail_q, cfg.tx_capacity);
	assign tx_head_nx = ring_next(tx_head_q, cfg.tx_capacity);
	assign rx_full    = (rx_tail_nx == rx_head_q);
	assign rx_empty   = (rx_head_q == rx_tail_q);
	assign tx_full    = (tx_tail_nx == tx_head_q);
	assign tx_empty   = (tx_head_q == tx_tail_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			urb_pkg::BK_IDLE:   if (go) state_d = urb_pkg::BK_FINISH;
			urb_pkg::BK_FINISH: state_d = urb_pkg::BK_IDLE;
		endcase
	end

	// state machine outputs: start only when the result slot frees by the finish edge
	always_comb begin
		go       = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			urb_pkg::BK_IDLE:   go = cmd_valid && (!out_valid_q || out_ch.ready);
			urb_pkg::BK_FINISH: load_res = 1'b1;
		endcase
	end

	assign cmd_pop = go;

	// command execution
	always_comb begin
		rx_head_d      = rx_head_q;
		rx_tail_d      = rx_tail_q;
		tx_head_d      = tx_head_q;
		tx_tail_d      = tx_tail_q;
		xoff_pend_d    = xoff_pend_q;
		rx_wait_d      = rx_wait_q;
		tx_wait_d      = tx_wait_q;
		rts_d          = rts_q;
		overrun_d      = overrun_q;
		parity_d       = parity_q;
		overrun_snap_d = overrun_snap_q;
		parity_snap_d  = parity_snap_q;
		valid_d        = 1'b0;
		acc_d          = 1'b0;
		changed_d      = 1'b0;
		ram_en         = 1'b0;
		ram_we         = 1'b0;
		ram_addr       = '0;
		ram_wdata      = cmd.data;
		if (go) begin
			if (cmd.parity) begin
				parity_d = parity_q + NW'(1);
			end
			unique case (cmd.kind)
				urb_pkg::CMD_RX_STORE: begin
					if (!room_above) begin
						if (sw_mode) begin
							xoff_pend_d = 1'b1;
							rx_wait_d   = 1'b1;
						end else if (hw_mode) begin
							rts_d = 1'b1;
						end
					end
					if (rx_full) begin
						overrun_d = overrun_q + NW'(1);
					end else begin
						ram_en    = 1'b1;
						ram_we    = 1'b1;
						ram_addr  = store_addr('0, rx_tail_q);
						rx_tail_d = rx_tail_nx;
						acc_d     = 1'b1;
					end
				end
				urb_pkg::CMD_XON:  tx_wait_d = 1'b0;
				urb_pkg::CMD_XOFF: tx_wait_d = 1'b1;
				urb_pkg::CMD_HOST_WR: begin
					if (!tx_full) begin
						ram_en    = 1'b1;
						ram_we    = 1'b1;
						ram_addr  = store_addr(cfg.rx_capacity, tx_tail_q);
						tx_tail_d = tx_tail_nx;
						acc_d     = 1'b1;
					end
				end
				urb_pkg::CMD_HOST_RD: begin
					if (!rx_empty) begin
						ram_en    = 1'b1;
						ram_addr  = store_addr('0, rx_head_q);
						rx_head_d = rx_head_nx;
						valid_d   = 1'b1;
					end
				end
				urb_pkg::CMD_TX_POP: begin
					// hold transmit after a received XOFF
					if (!(sw_mode && tx_wait_q) && !tx_empty) begin
						ram_en    = 1'b1;
						ram_addr  = store_addr(cfg.rx_capacity, tx_head_q);
						tx_head_d = tx_head_nx;
						valid_d   = 1'b1;
					end
				end
				urb_pkg::CMD_TICK: begin
					if (sw_mode) begin
						if (xoff_pend_q) begin
							xoff_pend_d = 1'b0;
							if (!tx_full) begin
								ram_en    = 1'b1;
								ram_we    = 1'b1;
								ram_addr  = store_addr(cfg.rx_capacity, tx_tail_q);
								ram_wdata = urb_pkg::XOFF_CODE;
								tx_tail_d = tx_tail_nx;
							end
						end
						if (rx_wait_q && room_above) begin
							rx_wait_d = 1'b0;
						end
					end else if (hw_mode) begin
						if (room_above) begin
							rts_d = 1'b0;
						end
					end
					if (overrun_q != overrun_snap_q || parity_q != parity_snap_q) begin
						overrun_snap_d = overrun_q;
						parity_snap_d  = parity_q;
						changed_d      = 1'b1;
					end
				end
				urb_pkg::CMD_NOP: ;
			endcase
		end
	end

	urb_ram #(
		.WIDTH(urb_pkg::DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= urb_pkg::BK_IDLE;
			rx_head_q      <= '0;
			rx_tail_q      <= '0;
			tx_head_q      <= '0;
			tx_tail_q      <= '0;
			xoff_pend_q    <= 1'b0;
			rx_wait_q      <= 1'b0;
			tx_wait_q      <= 1'b0;
			rts_q          <= 1'b0;
			overrun_q      <= '0;
			parity_q       <= '0;
			overrun_snap_q <= '0;
			parity_snap_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q        <= state_d;
			xoff_pend_q    <= xoff_pend_d;
			rx_wait_q      <= rx_wait_d;
			tx_wait_q      <= tx_wait_d;
			rts_q          <= rts_d;
			overrun_q      <= overrun_d;
			parity_q       <= parity_d;
			overrun_snap_q <= overrun_snap_d;
			parity_snap_q  <= parity_snap_d;
			if (rings_clear) begin
				rx_head_q <= '0;
				rx_tail_q <= '0;
				tx_head_q <= '0;
				tx_tail_q <= '0;
			end else begin
				rx_head_q <= rx_head_d;
				rx_tail_q <= rx_tail_d;
				tx_head_q <= tx_head_d;
				tx_tail_q <= tx_tail_d;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			valid_s1   <= valid_d;
			acc_s1     <= acc_d;
			changed_s1 <= changed_d;
		end
	end

	// state registers already hold the post-step values here
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.data_out       <= valid_s1 ? ram_rdata : '0;
			res_q.data_valid     <= valid_s1;
			res_q.accepted       <= acc_s1;
			res_q.rts_high       <= rts_q;
			res_q.tx_paused      <= tx_wait_q;
			res_q.rx_waiting     <= rx_wait_q;
			res_q.rx_used        <= rx_used_now;
			res_q.tx_used        <= ring_used(tx_head_q, tx_tail_q, cfg.tx_capacity);
			res_q.overrun_count  <= overrun_q;
			res_q.parity_count   <= parity_q;
			res_q.errors_changed <= changed_s1;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.data_out       = res_q.data_out;
	assign out_ch.data_valid     = res_q.data_valid;
	assign out_ch.accepted       = res_q.accepted;
	assign out_ch.rts_high       = res_q.rts_high;
	assign out_ch.tx_paused      = res_q.tx_paused;
	assign out_ch.rx_waiting     = res_q.rx_waiting;
	assign out_ch.rx_used        = res_q.rx_used;
	assign out_ch.tx_used        = res_q.tx_used;
	assign out_ch.overrun_count  = res_q.overrun_count;
	assign out_ch.parity_count   = res_q.parity_count;
	assign out_ch.errors_changed = res_q.errors_changed;

	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == urb_pkg::BK_FINISH) |-> !out_valid_q)
		else $error("result register still occupied at finish");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == urb_pkg::BK_FINISH))
		else $error("result raised outside finish");

	a_pop_or_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.data_valid && res_q.accepted))
		else $error("item both popped and stored a byte");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.rx_capacity >= CW'(2) && cfg.tx_capacity >= CW'(2)) |->
		(rx_head_q < cfg.rx_capacity && rx_tail_q < cfg.rx_capacity &&
		 tx_head_q < cfg.tx_capacity && tx_tail_q < cfg.tx_capacity))
		else $error("ring position beyond capacity");

endmodule
